@@ rtl/fat12_pkg.sv @@
package fat12_pkg;

    localparam int CL_W          = 12;    // cluster number / entry width
    localparam int CNT_W         = 13;    // entry_count register width
    localparam int CLUSTER_SPACE = 4096;  // visit map covers every cluster number
    localparam int DEF_MAX_ENTRIES = 4096;
    localparam int EPOCH_W       = 8;     // visit tag width

    localparam logic [CL_W-1:0] END_MARK = 12'hFF0;
    localparam logic [CL_W-1:0] MIN_LINK = 12'd3;

    typedef enum logic [1:0] {
        REQ_LOAD  = 2'd0,
        REQ_CHECK = 2'd1,
        REQ_CHAIN = 2'd2,
        REQ_NONE  = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        CH_NONE  = 2'd0,
        CH_CLEAN = 2'd1,
        CH_LOOP  = 2'd2,
        CH_EMPTY = 2'd3
    } chain_t;

    typedef enum logic [0:0] {
        REG_ENTRY_COUNT = 1'b0
    } reg_idx_t;

    typedef struct packed {
        logic [1:0]      req_type;
        logic [CL_W-1:0] index;
        logic [CL_W-1:0] value_first;
        logic [CL_W-1:0] value_second;
    } in_t;

    typedef struct packed {
        logic            first_bad_value;
        logic            second_bad_value;
        logic            copies_differ;
        logic [1:0]      chain_status;
        logic [CL_W-1:0] fault_index;
        logic            mark_bad;
        logic            range_error;
    } out_t;

    function automatic logic illegal_link(input logic [CL_W-1:0] v,
                                          input logic [CNT_W-1:0] count);
        return ((v != '0) && (v < MIN_LINK)) ||
               (({1'b0, v} > count) && (v < END_MARK));
    endfunction

    function automatic logic walkable(input logic [CL_W-1:0] c);
        return (c >= MIN_LINK) && (c < END_MARK);
    endfunction

endpackage

@@ rtl/fat12_table_consistency_checker.sv @@
// Path: load, range error or unused request pass through S_FIN to the output register;
// check entry without a difference goes through S_EVAL and S_FIN; a walk visits
// clusters in S_WALK, one read of copy 1 and of the visit map per cluster visited.
// Throughput: one transaction at a time; the next is taken once the previous result sits in the output register.
// Reset: both copies and the visit map are swept to zero, no input taken meanwhile;
// the visit map is swept again after every 255 walks.
module fat12_table_consistency_checker
    import fat12_pkg::*;
#(
    parameter int MAX_ENTRIES = DEF_MAX_ENTRIES
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  in_t         in_data,
    output logic        out_valid,
    input  logic        out_stall,
    output out_t        out_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int AW = $clog2(MAX_ENTRIES);
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_ENTRIES);

    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_EVAL  = 6'b000100,
        S_WALK  = 6'b001000,
        S_FIN   = 6'b010000,
        S_SPARE = 6'b100000
    } state_t;

    state_t               state_reg, state_next;
    logic [CNT_W-1:0]     entry_count_reg;
    logic [CNT_W-1:0]     eff_count;
    logic [CL_W-1:0]      cur_reg, cur_next;
    logic [CL_W-1:0]      clr_cnt_reg, clr_cnt_next;
    logic                 clr_tables_reg, clr_tables_next;
    logic [EPOCH_W-1:0]   epoch_reg, epoch_next;
    logic                 hazard_reg, hazard_next;
    logic                 fb_reg, fb_next, sb_reg, sb_next, diff_reg, diff_next;
    out_t                 res_reg, res_next;
    out_t                 out_reg, out_next;
    logic                 out_valid_reg, out_valid_next;

    // memories
    logic [CL_W-1:0]      first_mem  [MAX_ENTRIES];
    logic [CL_W-1:0]      second_mem [MAX_ENTRIES];
    logic [EPOCH_W-1:0]   vis_mem    [CLUSTER_SPACE];
    logic [CL_W-1:0]      fq, sq;
    logic [EPOCH_W-1:0]   vq;
    logic                 oob_q;
    logic [CL_W-1:0]      fq_eff, sq_eff;

    logic                 tbl_we;
    logic [AW-1:0]        tbl_waddr;
    logic [CL_W-1:0]      tbl_wd1, tbl_wd2;
    logic                 vis_we;
    logic [CL_W-1:0]      vis_waddr;
    logic [EPOCH_W-1:0]   vis_wd;
    logic [CL_W-1:0]      rd_cl;

    logic                 walk_go, fin_go;
    logic [CL_W-1:0]      walk_from;
    chain_t               fin_status;
    logic [CL_W-1:0]      fin_fault;
    logic                 fb_c, sb_c, diff_c;
    logic                 hit;
    logic                 cfg_wr;

    assign eff_count = (entry_count_reg > MAX_CNT) ? MAX_CNT : entry_count_reg;
    assign fq_eff    = oob_q ? '0 : fq;
    assign sq_eff    = oob_q ? '0 : sq;
    assign hit       = (vq == epoch_reg) || hazard_reg;

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    always_comb
    begin
        prdata = '0;
        if (paddr[2] == REG_ENTRY_COUNT)
        begin
            prdata = {{(32-CNT_W){1'b0}}, entry_count_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_count_reg <= MAX_CNT;
        end
        else if (cfg_wr && (paddr[2] == REG_ENTRY_COUNT))
        begin
            entry_count_reg <= pwdata[CNT_W-1:0];
        end
    end

    // memory ports: one write and one registered read each
    always_ff @(posedge clk)
    begin
        if (tbl_we)
        begin
            first_mem[tbl_waddr]  <= tbl_wd1;
            second_mem[tbl_waddr] <= tbl_wd2;
        end
        if (vis_we)
        begin
            vis_mem[vis_waddr] <= vis_wd;
        end
        fq    <= first_mem[rd_cl[AW-1:0]];
        sq    <= second_mem[rd_cl[AW-1:0]];
        vq    <= vis_mem[rd_cl];
        oob_q <= ({1'b0, rd_cl} >= MAX_CNT);
    end

    always_comb
    begin
        state_next      = state_reg;
        cur_next        = cur_reg;
        clr_cnt_next    = clr_cnt_reg;
        clr_tables_next = clr_tables_reg;
        epoch_next      = epoch_reg;
        hazard_next     = 1'b0;
        fb_next         = fb_reg;
        sb_next         = sb_reg;
        diff_next       = diff_reg;
        res_next        = res_reg;
        out_next        = out_reg;
        out_valid_next  = out_valid_reg && out_stall;
        tbl_we          = 1'b0;
        tbl_waddr       = cur_reg[AW-1:0];
        tbl_wd1         = '0;
        tbl_wd2         = '0;
        vis_we          = 1'b0;
        vis_waddr       = cur_reg;
        vis_wd          = epoch_reg;
        rd_cl           = cur_reg;
        walk_go         = 1'b0;
        walk_from       = cur_reg;
        fin_go          = 1'b0;
        fin_status      = CH_NONE;
        fin_fault       = '0;
        fb_c            = fb_reg;
        sb_c            = sb_reg;
        diff_c          = diff_reg;

        unique case (state_reg)
            S_CLEAR:
            begin
                vis_we    = 1'b1;
                vis_waddr = clr_cnt_reg;
                vis_wd    = '0;
                if (clr_tables_reg && ({1'b0, clr_cnt_reg} < MAX_CNT))
                begin
                    tbl_we    = 1'b1;
                    tbl_waddr = clr_cnt_reg[AW-1:0];
                end
                if (clr_cnt_reg == '1)
                begin
                    state_next      = S_IDLE;
                    clr_tables_next = 1'b0;
                    epoch_next      = '0;
                    clr_cnt_next    = '0;
                end
                else
                begin
                    clr_cnt_next = clr_cnt_reg + 1'b1;
                end
            end
            S_IDLE:
            begin
                rd_cl = in_data.index;
                if (in_valid)
                begin
                    cur_next  = in_data.index;
                    fb_next   = 1'b0;
                    sb_next   = 1'b0;
                    diff_next = 1'b0;
                    fb_c      = 1'b0;
                    sb_c      = 1'b0;
                    diff_c    = 1'b0;
                    res_next  = '0;
                    priority if (in_data.req_type == REQ_NONE)
                    begin
                        state_next = S_FIN;
                    end
                    else if ({1'b0, in_data.index} >= eff_count)
                    begin
                        res_next.range_error = 1'b1;
                        state_next           = S_FIN;
                    end
                    else if (in_data.req_type == REQ_LOAD)
                    begin
                        tbl_we     = 1'b1;
                        tbl_waddr  = in_data.index[AW-1:0];
                        tbl_wd1    = in_data.value_first;
                        tbl_wd2    = in_data.value_second;
                        state_next = S_FIN;
                    end
                    else if (in_data.req_type == REQ_CHECK)
                    begin
                        state_next = S_EVAL;
                    end
                    else
                    begin
                        walk_go   = 1'b1;
                        walk_from = in_data.index;
                    end
                end
            end
            S_EVAL:
            begin
                fb_c      = illegal_link(fq_eff, eff_count);
                sb_c      = !fb_c && illegal_link(sq_eff, eff_count);
                diff_c    = (fq_eff != sq_eff);
                fb_next   = fb_c;
                sb_next   = sb_c;
                diff_next = diff_c;
                if (diff_c)
                begin
                    walk_go   = 1'b1;
                    walk_from = cur_reg;
                end
                else
                begin
                    fin_go = 1'b1;
                end
            end
            S_WALK:
            begin
                if (hit)
                begin
                    fin_go     = 1'b1;
                    fin_status = CH_LOOP;
                    fin_fault  = cur_reg;
                end
                else
                begin
                    vis_we = 1'b1;
                    if (walkable(fq_eff))
                    begin
                        cur_next    = fq_eff;
                        rd_cl       = fq_eff;
                        // self link: the mark written now is not yet in the read data
                        hazard_next = (fq_eff == cur_reg);
                    end
                    else if (fq_eff < MIN_LINK)
                    begin
                        fin_go     = 1'b1;
                        fin_status = CH_EMPTY;
                        fin_fault  = cur_reg;
                    end
                    else
                    begin
                        fin_go     = 1'b1;
                        fin_status = CH_CLEAN;
                    end
                end
            end
            S_FIN:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = (epoch_reg == '1) ? S_CLEAR : S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (walk_go)
        begin
            if (walkable(walk_from))
            begin
                rd_cl       = walk_from;
                cur_next    = walk_from;
                epoch_next  = epoch_reg + 1'b1;
                hazard_next = 1'b0;
                state_next  = S_WALK;
            end
            else
            begin
                fin_go     = 1'b1;
                fin_status = (walk_from < MIN_LINK) ? CH_EMPTY : CH_CLEAN;
                fin_fault  = (walk_from < MIN_LINK) ? walk_from : '0;
            end
        end

        if (fin_go)
        begin
            res_next.first_bad_value  = fb_c;
            res_next.second_bad_value = sb_c;
            res_next.copies_differ    = diff_c;
            res_next.chain_status     = fin_status;
            res_next.fault_index      = fin_fault;
            res_next.mark_bad         = fb_c || (fin_status == CH_LOOP) ||
                                        (fin_status == CH_EMPTY);
            res_next.range_error      = 1'b0;
            state_next                = S_FIN;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            clr_cnt_reg    <= '0;
            clr_tables_reg <= 1'b1;
            epoch_reg      <= '0;
            hazard_reg     <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_cnt_reg    <= clr_cnt_next;
            clr_tables_reg <= clr_tables_next;
            epoch_reg      <= epoch_next;
            hazard_reg     <= hazard_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg  <= cur_next;
        fb_reg   <= fb_next;
        sb_reg   <= sb_next;
        diff_reg <= diff_next;
        res_reg  <= res_next;
        out_reg  <= out_next;
    end

    // checks
    a_walk_epoch: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WALK) |-> (epoch_reg != '0))
        else $error("walk running with the cleared visit tag");

    a_clear_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) |-> in_stall)
        else $error("input taken during clearing sweep");

    a_fault_marks_bad: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && ((out_reg.chain_status == CH_LOOP) ||
                           (out_reg.chain_status == CH_EMPTY))) |-> out_reg.mark_bad)
        else $error("loop or empty marker without mark_bad");

    a_range_alone: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.range_error) |->
            (!out_reg.mark_bad && !out_reg.copies_differ &&
             (out_reg.chain_status == CH_NONE) && !out_reg.first_bad_value))
        else $error("range error carries other flags");

    a_second_only: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.second_bad_value) |-> !out_reg.first_bad_value)
        else $error("both copy flags set");

endmodule
